>>> rtl/core/oasd_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the atom stream decoder.
// No dependencies; imported by every module of the core.
package oasd_pkg;

  localparam int TDATA_W = 96;  // payload_byte, atom_length, int_value
  localparam int TUSER_W = 9;   // payload_valid, atom_type, encoding, error_code

  // One decoded result, as it travels from the front through the queue to the back.
  typedef struct packed {
    logic [2:0]  error_code;
    logic [63:0] int_value;
    logic [23:0] atom_length;
    logic [2:0]  encoding;
    logic [1:0]  atom_type;
    logic        atom_done;
    logic [7:0]  payload_byte;
    logic        payload_valid;
  } res_t;

endpackage

>>> rtl/core/oasd_front.sv
`timescale 1ns / 1ps
// Front end: token parser. Takes one raw byte per transfer and produces at
// most one result for the queue. Depends on oasd_pkg.
module oasd_front import oasd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_accept,
  input  logic [7:0] in_byte,
  input  logic       in_end,
  output logic       res_valid,
  output res_t       res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_HEADER  = 3'd1;
  localparam logic [2:0] PH_INT     = 3'd2;
  localparam logic [2:0] PH_BIN     = 3'd3;
  localparam logic [2:0] PH_DISCARD = 3'd4;

  localparam logic [1:0] T_EMPTY = 2'd0;
  localparam logic [1:0] T_UINT  = 2'd1;
  localparam logic [1:0] T_INT   = 2'd2;
  localparam logic [1:0] T_BIN   = 2'd3;

  localparam logic [2:0] E_NONE   = 3'd0;
  localparam logic [2:0] E_TINY   = 3'd1;
  localparam logic [2:0] E_SHORT  = 3'd2;
  localparam logic [2:0] E_MEDIUM = 3'd3;
  localparam logic [2:0] E_LONG   = 3'd4;

  localparam logic [2:0] ERR_TOKEN  = 3'd1;
  localparam logic [2:0] ERR_TYPE   = 3'd2;
  localparam logic [2:0] ERR_INTLEN = 3'd3;
  localparam logic [2:0] ERR_TRUNC  = 3'd4;

  localparam logic [7:0] TOK_EMPTY    = 8'hFF;
  localparam logic [7:0] TOK_RESERVED = 8'hE4;

  logic [2:0]  phase_r, phase_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  logic [23:0] len_r, len_nxt;
  logic [23:0] rem_r, rem_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [2:0]  enc_r, enc_nxt;

  logic [23:0] rem_dec;
  logic [63:0] acc_base;
  logic        do_fin;
  logic [23:0] fin_len;
  logic        fail_req;
  logic [2:0]  fail_code;
  logic        go_header;
  logic [1:0]  flags;

  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    len_nxt   = len_r;
    rem_nxt   = rem_r;
    acc_nxt   = acc_r;
    type_nxt  = type_r;
    enc_nxt   = enc_r;
    res_valid = 1'b0;
    res       = '0;
    do_fin    = 1'b0;
    fin_len   = len_r;
    fail_req  = 1'b0;
    fail_code = ERR_TRUNC;
    go_header = 1'b0;
    flags     = 2'd0;
    rem_dec   = rem_r - 24'd1;
    acc_base  = acc_r;

    if (in_accept) begin
      case (phase_r)
        PH_HEADER: begin
          // Shift in one more length byte.
          len_nxt  = {len_r[15:0], in_byte};
          hidx_nxt = hidx_r - 2'd1;
          if (hidx_nxt == 2'd0) begin
            do_fin  = 1'b1;
            fin_len = len_nxt;
          end else if (in_end) begin
            fail_req = 1'b1;
          end
        end
        PH_INT: begin
          // Sign-extend from the first payload byte of a signed integer.
          if (rem_r == len_r && type_r == T_INT && in_byte[7]) begin
            acc_base = '1;
          end
          acc_nxt = {acc_base[55:0], in_byte};
          rem_nxt = rem_dec;
          if (rem_dec == 24'd0) begin
            phase_nxt       = PH_IDLE;
            res_valid       = 1'b1;
            res.atom_done   = 1'b1;
            res.atom_type   = type_r;
            res.encoding    = enc_r;
            res.atom_length = len_r;
            res.int_value   = acc_nxt;
          end else if (in_end) begin
            fail_req = 1'b1;
          end
        end
        PH_BIN: begin
          rem_nxt = rem_dec;
          if (rem_dec == 24'd0 || !in_end) begin
            res_valid         = 1'b1;
            res.payload_valid = 1'b1;
            res.payload_byte  = in_byte;
            res.atom_done     = (rem_dec == 24'd0);
            res.atom_type     = type_r;
            res.encoding      = enc_r;
            res.atom_length   = len_r;
            if (rem_dec == 24'd0) begin
              phase_nxt = PH_IDLE;
            end
          end else begin
            fail_req = 1'b1;
          end
        end
        PH_DISCARD: begin
          if (in_end) begin
            phase_nxt = PH_IDLE;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
          if (in_byte == TOK_EMPTY) begin
            type_nxt      = T_EMPTY;
            enc_nxt       = E_NONE;
            res_valid     = 1'b1;
            res.atom_done = 1'b1;
            res.atom_type = T_EMPTY;
            res.encoding  = E_NONE;
          end else if (!in_byte[7]) begin
            // Tiny atom: value lives in the token byte itself.
            type_nxt      = in_byte[6] ? T_INT : T_UINT;
            enc_nxt       = E_TINY;
            res_valid     = 1'b1;
            res.atom_done = 1'b1;
            res.atom_type = type_nxt;
            res.encoding  = E_TINY;
            res.int_value = {{58{in_byte[6] & in_byte[5]}}, in_byte[5:0]};
          end else if (in_byte >= TOK_RESERVED) begin
            fail_req  = 1'b1;
            fail_code = ERR_TOKEN;
          end else if (!in_byte[6]) begin
            enc_nxt = E_SHORT;
            flags   = in_byte[5:4];
            if (flags == 2'd3) begin
              fail_req  = 1'b1;
              fail_code = ERR_TYPE;
            end else begin
              type_nxt = flags + 2'd1;
              len_nxt  = {20'd0, in_byte[3:0]};
              do_fin   = 1'b1;
              fin_len  = len_nxt;
            end
          end else if (!in_byte[5]) begin
            enc_nxt = E_MEDIUM;
            flags   = in_byte[4:3];
            if (flags == 2'd3) begin
              fail_req  = 1'b1;
              fail_code = ERR_TYPE;
            end else begin
              type_nxt  = flags + 2'd1;
              len_nxt   = {21'd0, in_byte[2:0]};
              hidx_nxt  = 2'd1;
              go_header = 1'b1;
            end
          end else begin
            enc_nxt = E_LONG;
            flags   = in_byte[1:0];
            if (flags == 2'd3) begin
              fail_req  = 1'b1;
              fail_code = ERR_TYPE;
            end else begin
              type_nxt  = flags + 2'd1;
              len_nxt   = 24'd0;
              hidx_nxt  = 2'd3;
              go_header = 1'b1;
            end
          end
        end
      endcase

      if (go_header) begin
        if (in_end) begin
          fail_req = 1'b1;
        end else begin
          phase_nxt = PH_HEADER;
        end
      end

      // Header complete: decide between payload, empty binary atom and errors.
      if (do_fin) begin
        if (type_nxt == T_BIN) begin
          if (fin_len == 24'd0) begin
            phase_nxt     = PH_IDLE;
            res_valid     = 1'b1;
            res.atom_done = 1'b1;
            res.atom_type = type_nxt;
            res.encoding  = enc_nxt;
          end else if (in_end) begin
            fail_req = 1'b1;
          end else begin
            rem_nxt   = fin_len;
            phase_nxt = PH_BIN;
          end
        end else if (fin_len == 24'd0 || fin_len > 24'd8) begin
          fail_req  = 1'b1;
          fail_code = ERR_INTLEN;
        end else if (in_end) begin
          fail_req = 1'b1;
        end else begin
          rem_nxt   = fin_len;
          acc_nxt   = '0;
          phase_nxt = PH_INT;
        end
      end

      // Error: report only the code, then drop bytes to the buffer end.
      if (fail_req) begin
        res_valid      = 1'b1;
        res            = '0;
        res.error_code = fail_code;
        phase_nxt      = in_end ? PH_IDLE : PH_DISCARD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hidx_r  <= 2'd0;
      len_r   <= 24'd0;
      rem_r   <= 24'd0;
      acc_r   <= 64'd0;
      type_r  <= T_EMPTY;
      enc_r   <= E_NONE;
    end else begin
      phase_r <= phase_nxt;
      hidx_r  <= hidx_nxt;
      len_r   <= len_nxt;
      rem_r   <= rem_nxt;
      acc_r   <= acc_nxt;
      type_r  <= type_nxt;
      enc_r   <= enc_nxt;
    end
  end

  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.error_code != 3'd0) |->
      (!res.atom_done && !res.payload_valid && res.int_value == 64'd0))
    else $error("error result carries atom fields");

  a_err_discard: assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.error_code != 3'd0 && !in_end) |=> (phase_r == PH_DISCARD))
    else $error("error without buffer end did not enter discard");

  a_discard_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && phase_r == PH_DISCARD) |=> (phase_r == PH_IDLE || phase_r == PH_DISCARD))
    else $error("discard left to a payload phase");

endmodule

>>> rtl/core/oasd_queue.sv
`timescale 1ns / 1ps
// Short result queue between the parser front and the output back.
// Depends on oasd_pkg for the result type.
module oasd_queue import oasd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  res_t push_data,
  output logic full,
  input  logic pop,
  output logic q_valid,
  output res_t q_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

  res_t          entries_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign full    = (count_r == CNT_FULL);
  assign q_valid = (count_r != '0);
  assign q_data  = entries_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (!full || pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("pop from empty queue");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_FULL)
    else $error("queue count out of range");

endmodule

>>> rtl/core/oasd_back.sv
`timescale 1ns / 1ps
// Back end: output register that pulls results from the queue and drives
// the result stream. Depends on oasd_pkg.
module oasd_back import oasd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  res_t               q_data,
  output logic               q_pop,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,
  output logic [TUSER_W-1:0] out_tuser,
  output logic               out_tlast
);

  logic valid_r, valid_nxt;
  res_t data_r;

  // Load whenever the register is empty or its result leaves this cycle.
  assign q_pop     = q_valid && (!valid_r || out_tready);
  assign valid_nxt = q_pop || (valid_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      data_r <= q_data;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = {data_r.int_value, data_r.atom_length, data_r.payload_byte};
  assign out_tuser  = {data_r.error_code, data_r.encoding, data_r.atom_type,
                       data_r.payload_valid};
  assign out_tlast  = data_r.atom_done;

  a_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (q_valid && !valid_r) |=> valid_r)
    else $error("pending result not loaded into empty output register");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && out_tready && !q_valid) |=> !valid_r)
    else $error("output register kept a taken result");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_tready) |=> (valid_r && $stable(data_r)))
    else $error("waiting result changed before it was taken");

endmodule

>>> rtl/core/opal_atom_stream_decoder_core.sv
`timescale 1ns / 1ps
// Top level of the storage atom stream decoder: parser front, result queue
// and output back end. Depends on oasd_pkg, oasd_front, oasd_queue, oasd_back.
//
//   channel | direction | tdata                    | tuser / tlast
//   in_     | sink      | raw token byte           | tlast = buffer end
//   out_    | source    | byte, length, int value  | tuser = flags/codes, tlast = atom done
//
// Cycles: one byte per clock is accepted while in_tready is high; each byte is parsed
//   in the cycle it is taken, and its result is written into the queue and then
//   loaded into the output register before it appears on out_. Sustained rate is
//   one byte per cycle while the queue has room, set by the parser step.
// Reset: rst_n synchronous, active low; parser returns to idle, queue empties.
// Stalls: in_tready drops only when the result queue (QUEUE_DEPTH entries)
//   is full; the output register keeps a waiting result while bytes flow in.
module opal_atom_stream_decoder_core import oasd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  // Input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [7:0]         in_tdata,   // [7:0] in_byte
  input  logic               in_tlast,   // buffer_end
  // Result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // [7:0] payload_byte, [31:8] atom_length,
                                         // [95:32] int_value
  output logic [TUSER_W-1:0] out_tuser,  // [0] payload_valid, [2:1] atom_type,
                                         // [5:3] encoding, [8:6] error_code
  output logic               out_tlast   // atom_done
);

  logic in_accept;
  logic res_valid;
  res_t res;
  logic q_full;
  logic q_valid;
  logic q_pop;
  res_t q_data;

  // Accept a byte whenever the queue has room for the result it may cause.
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  oasd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_accept (in_accept),
    .in_byte   (in_tdata),
    .in_end    (in_tlast),
    .res_valid (res_valid),
    .res       (res)
  );

  oasd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_valid),
    .push_data (res),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  oasd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for opal_atom_stream_decoder_core: directed and random token-stream bytes in,
// decoded atoms checked against an in-bench parser model. Depends on oasd_pkg and the core.
module tb;
  import oasd_pkg::*;

  // Atom kinds, header encodings and error codes as they appear on out_tuser.
  localparam logic [1:0] TY_EMPTY = 2'd0, TY_UINT = 2'd1, TY_SINT = 2'd2, TY_BIN = 2'd3;
  localparam logic [2:0] ENC_NONE = 3'd0, ENC_TINY = 3'd1, ENC_SHORT = 3'd2,
                         ENC_MEDIUM = 3'd3, ENC_LONG = 3'd4;
  localparam logic [2:0] ERR_NONE = 3'd0, ERR_TOKEN = 3'd1, ERR_TYPE = 3'd2,
                         ERR_INT_LEN = 3'd3, ERR_TRUNC = 3'd4;
  // Token byte boundaries.
  localparam logic [7:0] TOK_SHORT = 8'h80, TOK_MEDIUM = 8'hC0, TOK_LONG = 8'hE0,
                         TOK_RESERVED = 8'hE4, TOK_EMPTY = 8'hFF;

  localparam int LIVE_ITEMS  = 630;   // bytes of well-formed or cut-short buffers in the random part
  localparam int TAIL_ITEMS  = 60;    // no idling once this few bytes are left
  localparam int PRESS_AT    = 400;   // receiver cycle from which the long hold-off may start
  localparam int PRESS_LEN   = 120;
  localparam int DRAIN       = 20;
  localparam int STUCK_LIMIT = 1000;

  typedef enum logic [2:0] {P_IDLE, P_HEADER, P_INT, P_BIN, P_DISCARD} parse_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } raw_byte_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [7:0]         in_tdata = 8'd0;
  logic               in_tlast = 1'b0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [TDATA_W-1:0] out_tdata;
  logic [TUSER_W-1:0] out_tuser;
  logic               out_tlast;

  opal_atom_stream_decoder_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  raw_byte_t   byte_stream[$];   // bytes waiting to be offered on in_
  logic [7:0]  frame[$];         // scratch buffer while building one token buffer
  res_t        atoms_due[$];     // decoded results still to come out of out_
  int          n_bad = 0;
  logic        calm = 1'b0;      // set by the driver near the end; stops new random receiver stalls

  // Parser model state.
  parse_t      ph;
  logic [1:0]  hdr_left;
  logic [23:0] hdr_len;
  logic [23:0] left;
  logic [63:0] acc;
  logic [1:0]  cur_ty;
  logic [2:0]  cur_enc;

  // ---------------------------------------------------------------------------
  // Parser model
  // ---------------------------------------------------------------------------
  function automatic logic [1:0] flag_type(input logic [1:0] f);
    return (f == 2'd0) ? TY_UINT : (f == 2'd1) ? TY_SINT : TY_BIN;
  endfunction

  task automatic emit_atom(input logic pv, input logic [7:0] pb, input logic done,
                           input logic [1:0] ty, input logic [2:0] enc,
                           input logic [23:0] len, input logic [63:0] val);
    res_t r;
    r.payload_valid = pv;
    r.payload_byte  = pb;
    r.atom_done     = done;
    r.atom_type     = ty;
    r.encoding      = enc;
    r.atom_length   = len;
    r.int_value     = val;
    r.error_code    = ERR_NONE;
    atoms_due.push_back(r);
  endtask

  // An error result carries nothing but its code; drop bytes up to the buffer end
  // unless the failing byte already is the buffer end.
  task automatic raise_error(input logic [2:0] code, input logic fin);
    res_t r;
    r = '0;
    r.error_code = code;
    atoms_due.push_back(r);
    if (fin) ph = P_IDLE;
    else ph = P_DISCARD;
  endtask

  // Header fully known: check the length; enter the payload, or emit an empty binary atom or an error.
  task automatic close_header(input logic fin);
    if (cur_ty == TY_BIN) begin
      if (hdr_len == 24'd0) begin
        ph = P_IDLE;
        emit_atom(1'b0, 8'd0, 1'b1, cur_ty, cur_enc, 24'd0, 64'd0);
      end else if (fin) begin
        raise_error(ERR_TRUNC, 1'b1);
      end else begin
        left = hdr_len;
        ph   = P_BIN;
      end
    end else if (hdr_len == 24'd0 || hdr_len > 24'd8) begin
      raise_error(ERR_INT_LEN, fin);
    end else if (fin) begin
      raise_error(ERR_TRUNC, 1'b1);
    end else begin
      left = hdr_len;
      acc  = 64'd0;
      ph   = P_INT;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic fin);
    logic [1:0]  f;
    logic [63:0] tv;
    case (ph)
      P_HEADER: begin
        hdr_len  = {hdr_len[15:0], b};
        hdr_left = hdr_left - 2'd1;
        if (hdr_left == 2'd0) close_header(fin);
        else if (fin) raise_error(ERR_TRUNC, 1'b1);
      end
      P_INT: begin
        // First byte of a signed payload with its top bit set: preload all ones.
        if (left == hdr_len && cur_ty == TY_SINT && b[7]) acc = '1;
        acc  = {acc[55:0], b};
        left = left - 24'd1;
        if (left == 24'd0) begin
          ph = P_IDLE;
          emit_atom(1'b0, 8'd0, 1'b1, cur_ty, cur_enc, hdr_len, acc);
        end else if (fin) begin
          raise_error(ERR_TRUNC, 1'b1);
        end
      end
      P_BIN: begin
        left = left - 24'd1;
        if (left == 24'd0) begin
          ph = P_IDLE;
          emit_atom(1'b1, b, 1'b1, cur_ty, cur_enc, hdr_len, 64'd0);
        end else if (fin) begin
          raise_error(ERR_TRUNC, 1'b1);
        end else begin
          emit_atom(1'b1, b, 1'b0, cur_ty, cur_enc, hdr_len, 64'd0);
        end
      end
      P_DISCARD: begin
        if (fin) ph = P_IDLE;
      end
      default: begin
        ph = P_IDLE;
        if (b == TOK_EMPTY) begin
          cur_ty  = TY_EMPTY;
          cur_enc = ENC_NONE;
          emit_atom(1'b0, 8'd0, 1'b1, TY_EMPTY, ENC_NONE, 24'd0, 64'd0);
        end else if (b < TOK_SHORT) begin
          cur_enc = ENC_TINY;
          cur_ty  = b[6] ? TY_SINT : TY_UINT;
          tv      = {58'd0, b[5:0]};
          if (b[6] && b[5]) tv[63:6] = '1;
          emit_atom(1'b0, 8'd0, 1'b1, cur_ty, ENC_TINY, 24'd0, tv);
        end else if (b >= TOK_RESERVED) begin
          raise_error(ERR_TOKEN, fin);
        end else if (b < TOK_MEDIUM) begin
          cur_enc = ENC_SHORT;
          f       = b[5:4];
          if (f == 2'b11) begin
            raise_error(ERR_TYPE, fin);
          end else begin
            cur_ty  = flag_type(f);
            hdr_len = {20'd0, b[3:0]};
            close_header(fin);
          end
        end else begin
          if (b < TOK_LONG) begin
            cur_enc  = ENC_MEDIUM;
            f        = b[4:3];
            hdr_left = 2'd1;
          end else begin
            cur_enc  = ENC_LONG;
            f        = b[1:0];
            hdr_left = 2'd3;
          end
          if (f == 2'b11) begin
            raise_error(ERR_TYPE, fin);
          end else begin
            cur_ty  = flag_type(f);
            hdr_len = (cur_enc == ENC_MEDIUM) ? {21'd0, b[2:0]} : 24'd0;
            if (fin) raise_error(ERR_TRUNC, 1'b1);
            else ph = P_HEADER;
          end
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus building
  // ---------------------------------------------------------------------------
  task automatic put(input logic [7:0] b, input logic fin);
    byte_stream.push_back('{data: b, last: fin});
  endtask

  // Append one well-formed atom to the frame.
  task automatic build_atom();
    int kind, flags, len;
    kind  = $urandom_range(0, 9);
    flags = $urandom_range(0, 2);   // unsigned, signed, binary
    len   = (flags == 2) ? $urandom_range(0, 12) : $urandom_range(1, 8);
    if (flags == 2 && kind >= 6 && $urandom_range(0, 3) == 0) len = $urandom_range(13, 40);
    case (kind)
      0: frame.push_back(TOK_EMPTY);
      1, 2: frame.push_back(8'($urandom_range(0, 127)));
      3, 4, 5: frame.push_back(TOK_SHORT | 8'(flags << 4) | 8'(len));
      6, 7: begin
        frame.push_back(TOK_MEDIUM | 8'(flags << 3) | 8'(len >> 8));
        frame.push_back(8'(len));
      end
      default: begin
        frame.push_back(TOK_LONG | 8'(flags));
        frame.push_back(8'(len >> 16));
        frame.push_back(8'(len >> 8));
        frame.push_back(8'(len));
      end
    endcase
    if (kind >= 3) repeat (len) frame.push_back(8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer queued bytes on in_, feed every transfer to the parser model
  // ---------------------------------------------------------------------------
  int        tx_gap;
  raw_byte_t nxt;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'd0;
      in_tlast  <= 1'b0;
      tx_gap    = 0;
      ph        = P_IDLE;
      hdr_left  = 2'd0;
      hdr_len   = 24'd0;
      left      = 24'd0;
      acc       = 64'd0;
      cur_ty    = TY_EMPTY;
      cur_enc   = ENC_NONE;
    end else begin
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
      if (in_tvalid && !in_tready) begin
        // hold the offered byte until it is taken
      end else if (tx_gap != 0) begin
        tx_gap = tx_gap - 1;
        in_tvalid <= 1'b0;
      end else if (byte_stream.size() == 0) begin
        in_tvalid <= 1'b0;
      end else if (byte_stream.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
        // random idle burst, this one included
        tx_gap = $urandom_range(0, 14);
        in_tvalid <= 1'b0;
      end else begin
        nxt = byte_stream.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= nxt.data;
        in_tlast  <= nxt.last;
      end
      calm <= (byte_stream.size() <= TAIL_ITEMS);
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts plus one long hold-off to fill the core
  // ---------------------------------------------------------------------------
  int   rx_cycle;
  int   rx_hold;
  logic pressed;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_cycle = 0;
      rx_hold  = 0;
      pressed  = 1'b0;
    end else begin
      rx_cycle = rx_cycle + 1;
      if (rx_hold != 0) begin
        rx_hold = rx_hold - 1;
        out_tready <= 1'b0;
      end else if (!pressed && rx_cycle >= PRESS_AT) begin
        // long hold-off while the driver keeps offering: queue fills, in_tready drops
        pressed = 1'b1;
        rx_hold = PRESS_LEN - 1;
        out_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
        rx_hold = $urandom_range(0, 14);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: compare each result transfer with the oldest expected atom
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.payload_valid = out_tuser[0];
      got.atom_type     = out_tuser[2:1];
      got.encoding      = out_tuser[5:3];
      got.error_code    = out_tuser[8:6];
      got.payload_byte  = out_tdata[7:0];
      got.atom_length   = out_tdata[31:8];
      got.int_value     = out_tdata[95:32];
      got.atom_done     = out_tlast;
      if (atoms_due.size() == 0) begin
        n_bad = n_bad + 1;
        if (n_bad <= 10) $display("%0t: result with none expected: %h", $realtime, got);
      end else begin
        want = atoms_due.pop_front();
        if (got !== want) begin
          n_bad = n_bad + 1;
          if (n_bad <= 10) begin
            $display("%0t: mismatch (pv pb done ty enc len val err)", $realtime);
            $display("  exp %b %h %b %0d %0d %h %h %0d", want.payload_valid,
                     want.payload_byte, want.atom_done, want.atom_type, want.encoding,
                     want.atom_length, want.int_value, want.error_code);
            $display("  got %b %h %b %0d %0d %h %h %0d", got.payload_valid,
                     got.payload_byte, got.atom_done, got.atom_type, got.encoding,
                     got.atom_length, got.int_value, got.error_code);
          end
        end
      end
    end
  end

  // Watchdog: end the run when no transfer happens on either side for too long.
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles == STUCK_LIMIT) begin
      $display("** opal_atom_stream_decoder_core: FAILED **");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus, reset and end of run
  // ---------------------------------------------------------------------------
  initial begin
    int live_items, pick, cut, hi, lo, s;
    live_items = 0;

    // Directed: empty, tiny extremes and signs, then short, medium and long atoms and errors
    put(TOK_EMPTY, 1'b0);
    put(8'h00, 1'b0);
    put(8'h3F, 1'b0);               // largest unsigned tiny
    put(8'h7F, 1'b0);               // signed tiny -1
    put(8'h60, 1'b1);               // signed tiny -32, on a buffer end
    put(TOK_SHORT | 8'h11, 1'b0);   // short signed, one byte, negative payload
    put(8'h80, 1'b0);
    put(TOK_SHORT | 8'h22, 1'b0);   // short binary, two bytes
    put(8'hAA, 1'b0);
    put(8'h55, 1'b0);
    put(TOK_SHORT | 8'h20, 1'b0);   // binary of length zero completes on its header
    put(TOK_MEDIUM, 1'b0);          // medium unsigned, one byte
    put(8'h01, 1'b0);
    put(8'hFF, 1'b0);
    put(TOK_LONG | 8'h02, 1'b0);    // long binary, one byte
    put(8'h00, 1'b0);
    put(8'h00, 1'b0);
    put(8'h01, 1'b0);
    put(8'h7E, 1'b1);
    put(TOK_SHORT, 1'b1);           // integer of length zero, failing byte ends the buffer
    put(TOK_RESERVED, 1'b0);        // reserved token, then drop up to the buffer end
    put(8'h12, 1'b1);
    put(TOK_SHORT | 8'h35, 1'b1);   // binary and sign flags both set
    put(TOK_SHORT | 8'h23, 1'b0);   // buffer ends inside a binary payload
    put(8'h11, 1'b1);

    // Random: mostly well-formed buffers, some cut short, the rest broken headers and noise
    while (live_items < LIVE_ITEMS) begin
      frame.delete();
      pick = $urandom_range(0, 19);
      if (pick < 15) begin
        repeat ($urandom_range(1, 6)) build_atom();
        if ($urandom_range(0, 7) == 0) begin
          cut = $urandom_range(1, frame.size());
          while (frame.size() > cut) void'(frame.pop_back());
        end
        live_items += frame.size();
      end else begin
        case (pick)
          15: frame.push_back(8'($urandom_range(TOK_RESERVED, TOK_EMPTY - 1)));
          16: begin
            case ($urandom_range(0, 2))
              0: frame.push_back(TOK_SHORT | 8'h30 | 8'($urandom_range(0, 15)));
              1: frame.push_back(TOK_MEDIUM | 8'h18 | 8'($urandom_range(0, 7)));
              default: frame.push_back(TOK_LONG | 8'h03);
            endcase
          end
          17: begin
            s = $urandom_range(0, 1);
            if ($urandom_range(0, 1) == 0) begin
              lo = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(9, 15);
              frame.push_back(TOK_SHORT | 8'(s << 4) | 8'(lo));
            end else begin
              hi = $urandom_range(0, 7);
              lo = $urandom_range(0, 255);
              if (hi == 0 && lo >= 1 && lo <= 8) lo = 0;
              frame.push_back(TOK_MEDIUM | 8'(s << 3) | 8'(hi));
              frame.push_back(8'(lo));
            end
          end
          18: begin
            // long binary with a wide random length, cut off by the buffer end
            frame.push_back(TOK_LONG | 8'h02);
            repeat (3) frame.push_back(8'($urandom));
          end
          default: repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom));
        endcase
        repeat ($urandom_range(0, 4)) frame.push_back(8'($urandom));
      end
      foreach (frame[i]) put(frame[i], i == frame.size() - 1);
    end

    rst_n = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (byte_stream.size() != 0 || in_tvalid || atoms_due.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_bad == 0) begin
      $display("** opal_atom_stream_decoder_core: PASSED **");
    end else begin
      $display("** opal_atom_stream_decoder_core: FAILED **");
    end
    $finish;
  end

endmodule

>>> opal_atom_stream_decoder_core.f
rtl/core/oasd_pkg.sv
rtl/core/oasd_front.sv
rtl/core/oasd_queue.sv
rtl/core/oasd_back.sv
rtl/core/opal_atom_stream_decoder_core.sv
verif/tb.sv
